FILE: hw/rtl/pldrc_pkg.sv
// ----------------------------------------------------------------------------
// pldrc_pkg
// Shared types and constants for the phase lock detector with replay check.
// ----------------------------------------------------------------------------
package pldrc_pkg;

    // field widths
    localparam int PE_W    = 24;
    localparam int TS_W    = 48;
    localparam int OMEGA_W = 64;
    localparam int SALT_W  = 10;
    localparam int SCORE_W = 17;
    localparam int SUM_W   = 20;
    localparam int DVD_W   = 64;
    localparam int DSR_W   = 32;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = 2 * SUM_W;

    // salt reduction widths
    localparam int FOLD_W      = 27;
    localparam int QUO_W       = 17;
    localparam int RECIP_W     = 28;
    localparam int SALT_PROD_W = FOLD_W + RECIP_W;

    // stream word widths
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 24;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_LOCK_IN  = 2'd0,
        REG_DROP_OUT = 2'd1,
        REG_WINDOW   = 2'd2
    } t_reg_idx;

    localparam logic [SCORE_W-1:0] LOCK_IN_RST  = 17'd52429;
    localparam logic [SCORE_W-1:0] DROP_OUT_RST = 17'd32768;
    localparam logic [DSR_W-1:0]   WINDOW_RST   = 32'd1000000;

    // arithmetic constants
    localparam logic [SCORE_W-1:0] SCORE_ONE   = 17'd65536;
    localparam logic [SUM_W-1:0]   RECIP10     = 20'd838861;  // ceil(2^23 / 10)
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [63:0]        FNV_BASIS   = 64'hCBF29CE484222325;
    localparam logic [8:0]         FNV_PRIME_LO = 9'h1B3;     // prime = 2^40 + 0x1B3
    localparam int                 FNV_PRIME_SH = 40;
    localparam logic [SALT_W-1:0]  SALT_MOD    = 10'd1000;
    // 2^16, 2^32, 2^48 modulo 1000, for folding the hash
    localparam logic [SALT_W-1:0]  MOD_2P16    = 10'd536;
    localparam logic [SALT_W-1:0]  MOD_2P32    = 10'd296;
    localparam logic [SALT_W-1:0]  MOD_2P48    = 10'd656;
    // ceil(2^37 / 1000); exact quotient for any folded value
    localparam logic [RECIP_W-1:0] SALT_RECIP  = 28'd137438954;
    localparam int                 SALT_SHIFT  = 37;
    localparam logic [CNT_W-1:0]   DIV_LAST    = 6'd63;
    localparam logic [CNT_W-1:0]   HASH_LAST   = 6'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA_SUM,
        ST_EMA_MUL,
        ST_DIV_TS,
        ST_HASH_INIT,
        ST_HASH,
        ST_SALT_FOLD,
        ST_SALT_QUO,
        ST_SALT_REM,
        ST_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       load;          // capture input word
        logic       ema_sum;       // score + 9*average
        logic       ema_mul;       // multiply by reciprocal of ten
        logic       div_load_ts;   // divider: timestamp / window
        logic       div_step;      // one restoring step
        logic       hash_init;     // seed hash and key
        logic       hash_step;     // fold one key byte
        logic       salt_fold;     // hash folded to a small value mod 1000
        logic       salt_quo;      // quotient by reciprocal of 1000
        logic       salt_rem;      // remainder = expected salt
        logic [2:0] byte_sel;
        logic       finish;        // update state, load result word
    } t_cmd;

endpackage

FILE: hw/rtl/pldrc_ctrl.sv
// ----------------------------------------------------------------------------
// pldrc_ctrl
// Sequencer: steps the datapath through score, epoch divide, hash and
// salt reduction; owns the stream handshakes.
// ----------------------------------------------------------------------------
module pldrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output pldrc_pkg::t_cmd o_cmd
);
    import pldrc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    // state, step counter, result-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_EMA_SUM;
            end
            ST_EMA_SUM: n_state = ST_EMA_MUL;
            ST_EMA_MUL: begin
                n_state = ST_DIV_TS;
                n_cnt   = '0;
            end
            ST_DIV_TS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) n_state = ST_HASH_INIT;
            end
            ST_HASH_INIT: begin
                n_state = ST_HASH;
                n_cnt   = '0;
            end
            ST_HASH: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == HASH_LAST) n_state = ST_SALT_FOLD;
            end
            ST_SALT_FOLD: n_state = ST_SALT_QUO;
            ST_SALT_QUO:  n_state = ST_SALT_REM;
            ST_SALT_REM:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.byte_sel = r_cnt[2:0];
        case (r_state)
            ST_IDLE:      o_cmd.load          = i_s_tvalid;
            ST_EMA_SUM:   o_cmd.ema_sum       = 1'b1;
            ST_EMA_MUL: begin
                o_cmd.ema_mul     = 1'b1;
                o_cmd.div_load_ts = 1'b1;
            end
            ST_DIV_TS:    o_cmd.div_step      = 1'b1;
            ST_HASH_INIT: o_cmd.hash_init     = 1'b1;
            ST_HASH:      o_cmd.hash_step     = 1'b1;
            ST_SALT_FOLD: o_cmd.salt_fold     = 1'b1;
            ST_SALT_QUO:  o_cmd.salt_quo      = 1'b1;
            ST_SALT_REM:  o_cmd.salt_rem      = 1'b1;
            ST_FINISH:    o_cmd.finish        = out_free;
            default:      o_cmd               = '0;
        endcase
    end

endmodule

FILE: hw/rtl/pldrc_dpath.sv
// ----------------------------------------------------------------------------
// pldrc_dpath
// Datapath: score and average, restoring divider for the epoch number,
// FNV-1a-64 hash, salt reduction, lock trigger and result word.
// ----------------------------------------------------------------------------
module pldrc_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pldrc_pkg::t_cmd                       i_cmd,
    input  logic [pldrc_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic [pldrc_pkg::SCORE_W-1:0]         i_lock_in,
    input  logic [pldrc_pkg::SCORE_W-1:0]         i_drop_out,
    input  logic [pldrc_pkg::DSR_W-1:0]           i_window,
    output logic [pldrc_pkg::M_TDATA_W-1:0]       o_m_tdata
);
    import pldrc_pkg::*;

    // captured input word
    logic [PE_W-1:0]    r_pe;
    logic [TS_W-1:0]    r_ts;
    logic [OMEGA_W-1:0] r_omega;
    logic [SALT_W-1:0]  r_salt;

    // average path
    logic [SUM_W-1:0]   r_sum;
    logic [PROD_W-1:0]  r_prod;
    logic [SCORE_W-1:0] r_avg;
    logic               r_lock;

    // divider and hash
    logic [DSR_W-1:0]   r_rem;
    logic [DVD_W-1:0]   r_dvd;
    logic [DSR_W-1:0]   r_dsr;
    logic [63:0]        r_hash;
    logic [63:0]        r_key;

    // salt reduction
    logic [FOLD_W-1:0]  r_fold;
    logic [QUO_W-1:0]   r_quo;
    logic [SALT_W-1:0]  r_exp;

    // result word
    logic               r_o_locked;
    logic               r_o_replay;
    logic [SCORE_W-1:0] r_o_ema;

    logic [PE_W-1:0]    mag;
    logic [30:0]        m100;
    logic [30:0]        sub;
    logic [SCORE_W-1:0] score;
    logic [DSR_W:0]     trial;
    logic               ge;
    logic [DSR_W-1:0]   n_rem;
    logic [63:0]        hx;
    logic [63:0]        n_hash;
    logic [FOLD_W-1:0]      fold;
    logic [SALT_PROD_W-1:0] salt_prod;
    logic [SCORE_W-1:0] avg_new;
    logic               lock_trig;
    logic               replay;

    // score = 65536 - ceil(100*|e| / 64), clamped at zero
    always_comb begin
        mag   = r_pe[PE_W-1] ? (PE_W'(0) - r_pe) : r_pe;
        m100  = 31'(mag) * 31'd100;
        sub   = (m100 + 31'd63) >> 6;
        score = (sub >= 31'(SCORE_ONE)) ? '0 : SCORE_W'(31'(SCORE_ONE) - sub);
    end

    // restoring divide step
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? DSR_W'(trial - {1'b0, r_dsr}) : trial[DSR_W-1:0];
    end

    // FNV-1a step; multiply by 2^40 + 0x1B3 modulo 2^64
    always_comb begin
        hx     = r_hash ^ {56'd0, r_key[8*i_cmd.byte_sel +: 8]};
        n_hash = (hx << FNV_PRIME_SH) + (hx * 64'(FNV_PRIME_LO));
    end

    // hash mod 1000: fold 16-bit chunks by their weights mod 1000, then
    // quotient by reciprocal multiplication
    always_comb begin
        fold = FOLD_W'(r_hash[15:0])
             + FOLD_W'(r_hash[31:16]) * FOLD_W'(MOD_2P16)
             + FOLD_W'(r_hash[47:32]) * FOLD_W'(MOD_2P32)
             + FOLD_W'(r_hash[63:48]) * FOLD_W'(MOD_2P48);
        salt_prod = SALT_PROD_W'(r_fold) * SALT_PROD_W'(SALT_RECIP);
    end

    // average / 10 by reciprocal, Schmitt trigger, salt compare
    always_comb begin
        avg_new = r_prod[RECIP_SHIFT +: SCORE_W];
        if (!r_lock && (avg_new >= i_lock_in))
            lock_trig = 1'b1;
        else if (r_lock && (avg_new < i_drop_out))
            lock_trig = 1'b0;
        else
            lock_trig = r_lock;
        replay = (r_salt != r_exp);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pe    <= i_s_tdata[PE_W-1:0];
            r_ts    <= i_s_tdata[PE_W +: TS_W];
            r_omega <= i_s_tdata[PE_W+TS_W +: OMEGA_W];
            r_salt  <= i_s_tdata[PE_W+TS_W+OMEGA_W +: SALT_W];
        end
        if (i_cmd.ema_sum)
            r_sum <= SUM_W'(score) + SUM_W'(r_avg) * SUM_W'(9);
        if (i_cmd.ema_mul)
            r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP10);
        if (i_cmd.div_load_ts) begin
            r_rem <= '0;
            r_dvd <= DVD_W'(r_ts);
            r_dsr <= (i_window == '0) ? DSR_W'(1) : i_window;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
        end
        if (i_cmd.hash_init) begin
            r_hash <= FNV_BASIS;
            r_key  <= r_dvd ^ r_omega;
        end else if (i_cmd.hash_step) begin
            r_hash <= n_hash;
        end
        if (i_cmd.salt_fold)
            r_fold <= fold;
        if (i_cmd.salt_quo)
            r_quo <= salt_prod[SALT_SHIFT +: QUO_W];
        if (i_cmd.salt_rem)
            r_exp <= SALT_W'(r_fold - FOLD_W'(r_quo) * FOLD_W'(SALT_MOD));
        if (i_cmd.finish) begin
            r_o_locked <= lock_trig && !replay;
            r_o_replay <= replay;
            r_o_ema    <= replay ? '0 : avg_new;
        end
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg  <= '0;
            r_lock <= 1'b0;
        end else if (i_cmd.finish) begin
            r_avg  <= replay ? '0 : avg_new;
            r_lock <= lock_trig && !replay;
        end
    end

    assign o_m_tdata = {{(M_TDATA_W-SCORE_W-2){1'b0}}, r_o_ema, r_o_replay, r_o_locked};

endmodule

FILE: hw/rtl/phase_lock_detector_replay_check_top.sv
// ----------------------------------------------------------------------------
// phase_lock_detector_replay_check_top
// Phase lock detector with salt-based replay check; APB register file.
// ----------------------------------------------------------------------------
//  Channel   Dir  Width  Contents
//  s_axis    in   152    phase_error, timestamp, omega_bits, salt_code
//  m_axis    out  24     locked, replay_detected, ema_score
//  apb       cfg  32     lock_in @0x0, drop_out @0x4, epoch_window @0x8
//
// One word is taken at a time; the input is not ready again until the
// result is loaded. The radix-2 divider for the epoch number takes 64
// steps, plus eight hash steps, three for the salt modulo and setup steps.
// Synchronous active-low reset clears the average, lock and handshakes.
// A result waiting on m_axis stalls only the final step of the next word.
module phase_lock_detector_replay_check_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input word: [23:0] phase_error, [71:24] timestamp,
    // [135:72] omega_bits, [145:136] salt_code
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [pldrc_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // result word: [0] locked, [1] replay_detected, [18:2] ema_score
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [pldrc_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pldrc_pkg::PADDR_W-1:0]         paddr,
    input  logic [pldrc_pkg::PDATA_W-1:0]         pwdata,
    output logic [pldrc_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready
);
    import pldrc_pkg::*;

    logic [SCORE_W-1:0] r_lock_in;
    logic [SCORE_W-1:0] r_drop_out;
    logic [DSR_W-1:0]   r_window;
    t_reg_idx           reg_idx;
    logic               wr_en;
    t_cmd               cmd;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_in  <= LOCK_IN_RST;
            r_drop_out <= DROP_OUT_RST;
            r_window   <= WINDOW_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOCK_IN:  r_lock_in  <= pwdata[SCORE_W-1:0];
                REG_DROP_OUT: r_drop_out <= pwdata[SCORE_W-1:0];
                REG_WINDOW:   r_window   <= pwdata;
                default:      ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_LOCK_IN:  prdata = PDATA_W'(r_lock_in);
            REG_DROP_OUT: prdata = PDATA_W'(r_drop_out);
            REG_WINDOW:   prdata = r_window;
            default:      prdata = '0;
        endcase
    end

    pldrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    pldrc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_tdata  (i_s_tdata),
        .i_lock_in  (r_lock_in),
        .i_drop_out (r_drop_out),
        .i_window   (r_window),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: hw/rtl/pldrc_checker.sv
// ----------------------------------------------------------------------------
// pldrc_checker
// Port-level checks for the phase lock detector, bound to the top level.
// ----------------------------------------------------------------------------
module pldrc_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    input  logic                                  o_s_tready,
    input  logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic [pldrc_pkg::M_TDATA_W-1:0]       o_m_tdata
);
    import pldrc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // a replay always reports unlocked with a cleared average
    a_replay_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> !o_m_tdata[0] && (o_m_tdata[18:2] == '0))
        else $error("replay word not cleared");

    // average never exceeds one, padding stays zero
    a_ema_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18:2] <= SCORE_ONE) && (o_m_tdata[23:19] == '0))
        else $error("result word out of range");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while busy");

endmodule

bind phase_lock_detector_replay_check_top pldrc_checker u_pldrc_checker (.*);

FILE: test/tb_phase_lock_detector_replay_check_top.sv
// ----------------------------------------------------------------------------
// tb_phase_lock_detector_replay_check_top
// Self-checking bench for the phase lock detector with replay check.
// A short directed walk covers the error extremes, score clamp edges, bad
// salts, zero window and threshold extremes. Random words follow in several
// register settings, mostly with a correct salt so that lock can build up.
// Every result word is checked against an in-bench score/lock/salt tracker.
// ----------------------------------------------------------------------------
module tb_phase_lock_detector_replay_check_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pldrc_pkg::*;

    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          N_PHASES        = 6;
    localparam int          WORDS_PER_PHASE = 210;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [63:0] FNV_OFFSET      = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_MULT        = 64'h00000100000001B3;
    localparam int          SALT_RANGE      = 1000;

    // input word, first field in the low bits
    typedef struct packed {
        logic [SALT_W-1:0]  salt;
        logic [OMEGA_W-1:0] omega;
        logic [TS_W-1:0]    ts;
        logic [PE_W-1:0]    pe;
    } t_word;

    // result word, first field in the low bits
    typedef struct packed {
        logic [SCORE_W-1:0] ema;
        logic               replay;
        logic               locked;
    } t_result;

    typedef enum logic { STEP_WORD, STEP_REG } t_step_kind;
    typedef enum logic { SALT_MATCH, SALT_GIVEN } t_salt_kind;

    typedef struct {
        t_step_kind  kind;
        t_reg_idx    idx;
        logic [31:0] val;
        t_word       w;
        t_salt_kind  sk;
        bit          known;
        t_result     typed;
    } t_step;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    // block inputs
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;

    // block outputs
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire  [PDATA_W-1:0]   prdata;
    wire                  pready;

    phase_lock_detector_replay_check_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // tracker state and register copy
    logic [SCORE_W-1:0] avg_track   = '0;
    logic               lock_track  = 1'b0;
    logic [SCORE_W-1:0] lock_in_cfg = 17'd52429;
    logic [SCORE_W-1:0] drop_cfg    = 17'd32768;
    logic [DSR_W-1:0]   window_cfg  = 32'd1000000;

    t_result lock_reports_due[$];
    t_step   plan[$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    bit      calm        = 1'b0;

    // salt the block expects: FNV-1a-64 of (epoch ^ omega), bytes LSB first
    function automatic logic [SALT_W-1:0] epoch_salt(logic [TS_W-1:0] ts,
                                                     logic [OMEGA_W-1:0] omega);
        logic [63:0] key;
        logic [63:0] h;
        logic [63:0] win;
        win = (window_cfg == '0) ? 64'd1 : {32'd0, window_cfg};
        key = ({16'd0, ts} / win) ^ omega;
        h   = FNV_OFFSET;
        for (int i = 0; i < 8; i++)
            h = (h ^ {56'd0, key[8*i +: 8]}) * FNV_MULT;
        return SALT_W'(h % SALT_RANGE);
    endfunction

    // score, average, Schmitt trigger and replay for one word
    function automatic t_result track_lock(t_word w);
        logic [24:0] mag;
        logic [31:0] sub;
        logic [31:0] score;
        logic [31:0] avg;
        t_result     r;
        mag   = w.pe[PE_W-1] ? (25'h1000000 - {1'b0, w.pe}) : {1'b0, w.pe};
        sub   = (32'(mag) * 32'd100 + 32'd63) >> 6;
        score = (sub >= 32'd65536) ? 32'd0 : (32'd65536 - sub);
        avg   = (score + 32'd9 * 32'(avg_track)) / 32'd10;
        avg_track = SCORE_W'(avg);
        if (!lock_track && avg_track >= lock_in_cfg)
            lock_track = 1'b1;
        else if (lock_track && avg_track < drop_cfg)
            lock_track = 1'b0;
        r.replay = (w.salt != epoch_salt(w.ts, w.omega));
        if (r.replay) begin
            avg_track  = '0;
            lock_track = 1'b0;
        end
        r.locked = lock_track;
        r.ema    = avg_track;
        return r;
    endfunction

    function automatic void flag_failure(string msg);
        if (fail_count < MAX_REPORTS)
            $display("%s", msg);
        fail_count++;
    endfunction

    function automatic t_step step_word(logic [PE_W-1:0] pe, logic [TS_W-1:0] ts,
                                        logic [OMEGA_W-1:0] omega, t_salt_kind sk,
                                        logic [SALT_W-1:0] salt, bit known,
                                        t_result typed);
        t_step s;
        s.kind  = STEP_WORD;
        s.idx   = REG_LOCK_IN;
        s.val   = '0;
        s.w     = {salt, omega, ts, pe};
        s.sk    = sk;
        s.known = known;
        s.typed = typed;
        return s;
    endfunction

    function automatic t_step step_reg(t_reg_idx idx, logic [31:0] val);
        t_step s;
        s = step_word('0, '0, '0, SALT_GIVEN, '0, 1'b0, '0);
        s.kind = STEP_REG;
        s.idx  = idx;
        s.val  = val;
        return s;
    endfunction

    // offer one word, idling at random first; track it once accepted
    task automatic push_word(t_word w, bit known, t_result typed);
        t_result r;
        while (!calm && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, w};
        do @(posedge i_clk); while (!s_tready);
        r = track_lock(w);
        lock_reports_due.push_back(known ? typed : r);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (lock_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup then access
    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LOCK_IN:  lock_in_cfg = val[SCORE_W-1:0];
            REG_DROP_OUT: drop_cfg    = val[SCORE_W-1:0];
            REG_WINDOW:   window_cfg  = val;
            default: ;
        endcase
    endtask

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random backpressure and in-order check
    always @(posedge i_clk) begin : result_side
        t_result got;
        t_result want;
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 19);
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[18:0]);
            if (lock_reports_due.size() == 0) begin
                flag_failure($sformatf("unexpected result word: locked=%0b replay=%0b ema=%0d",
                                       got.locked, got.replay, got.ema));
            end else begin
                want = lock_reports_due.pop_front();
                if (got.locked !== want.locked || got.replay !== want.replay ||
                    got.ema !== want.ema)
                    flag_failure($sformatf(
                        "mismatch: exp locked=%0b replay=%0b ema=%0d, got locked=%0b replay=%0b ema=%0d",
                        want.locked, want.replay, want.ema,
                        got.locked, got.replay, got.ema));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_word             w;
        t_step             s;
        int                roll;
        int                mag;
        bit                clean;
        logic [SCORE_W-1:0] lock_in_set [N_PHASES];
        logic [SCORE_W-1:0] drop_set    [N_PHASES];
        logic [DSR_W-1:0]   window_set  [N_PHASES];

        // directed walk; typed results only where obvious
        plan.push_back(step_word(24'h000000, 48'h0, 64'h0, SALT_MATCH, '0,
                                 1'b1, {17'd6553, 1'b0, 1'b0}));
        plan.push_back(step_word(24'h7FFFFF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                 SALT_MATCH, '0, 1'b1, {17'd5897, 1'b0, 1'b0}));
        plan.push_back(step_word(24'h800000, 48'd123456789, 64'h400921FB54442D18,
                                 SALT_MATCH, '0, 1'b0, '0));
        // score clamp edges: one LSB left, then exactly zero
        plan.push_back(step_word(24'h00A3D6, 48'd42, 64'h5555_AAAA_5555_AAAA,
                                 SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_word(24'hFF5C2A, 48'd999999, 64'hAAAA_5555_AAAA_5555,
                                 SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_word(24'h00A3D7, 48'd1000000, 64'h8000_0000_0000_0001,
                                 SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_word(24'h000001, 48'd7, 64'h3FF0_0000_0000_0000,
                                 SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_word(24'hFFFFFF, 48'd8, 64'h3FF0_0000_0000_0000,
                                 SALT_MATCH, '0, 1'b0, '0));
        // given salts: codes out of range never match, a zero code is left to the tracker
        plan.push_back(step_word(24'h000000, 48'd5, 64'h1, SALT_GIVEN, 10'd1000,
                                 1'b1, {17'd0, 1'b1, 1'b0}));
        plan.push_back(step_word(24'h000000, 48'd6, 64'h2, SALT_GIVEN, 10'd1023,
                                 1'b1, {17'd0, 1'b1, 1'b0}));
        plan.push_back(step_word(24'h000010, 48'd9, 64'h3, SALT_GIVEN, 10'd0,
                                 1'b0, '0));
        // zero lock-in locks at once; full drop-out then toggles lock
        plan.push_back(step_reg(REG_LOCK_IN, 32'd0));
        plan.push_back(step_word(24'h000000, 48'd10, 64'h4, SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_reg(REG_DROP_OUT, 32'd65536));
        plan.push_back(step_word(24'h000000, 48'd11, 64'h5, SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_word(24'h000000, 48'd12, 64'h6, SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_word(24'h000000, 48'd13, 64'h7, SALT_GIVEN, 10'd1000,
                                 1'b1, {17'd0, 1'b1, 1'b0}));
        // zero window counts as one
        plan.push_back(step_reg(REG_WINDOW, 32'd0));
        plan.push_back(step_word(24'h000200, 48'h0123_4567_89AB, 64'hDEAD_BEEF_0000_0001,
                                 SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_reg(REG_WINDOW, 32'd1));
        plan.push_back(step_word(24'hFFFE00, 48'h0123_4567_89AB, 64'hDEAD_BEEF_0000_0001,
                                 SALT_MATCH, '0, 1'b0, '0));
        plan.push_back(step_reg(REG_WINDOW, 32'hFFFF_FFFF));
        plan.push_back(step_word(24'h000000, 48'hFFFF_FFFF_FFFF, 64'h0, SALT_MATCH, '0,
                                 1'b0, '0));
        plan.push_back(step_reg(REG_LOCK_IN, 32'd65536));
        plan.push_back(step_reg(REG_DROP_OUT, 32'd0));
        plan.push_back(step_word(24'h000000, 48'd77, 64'h9, SALT_MATCH, '0, 1'b0, '0));

        // register settings for the random phases, extremes first
        lock_in_set = '{17'd52429, 17'd0, 17'd65536, 17'h1FFFF, 17'd0, 17'd0};
        drop_set    = '{17'd32768, 17'd0, 17'd65536, 17'h1FFFF, 17'd0, 17'd0};
        window_set  = '{32'd1000000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
        for (int ph = 4; ph < N_PHASES; ph++) begin
            lock_in_set[ph] = SCORE_W'($urandom_range(30000, 65536));
            drop_set[ph]    = SCORE_W'($urandom_range(0, lock_in_set[ph]));
        end
        window_set[4] = $urandom_range(1, 5000000);
        window_set[5] = $urandom;

        // reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            s = plan[k];
            if (s.kind == STEP_REG) begin
                settle();
                reg_write(s.idx, s.val);
            end else begin
                w = s.w;
                if (s.sk == SALT_MATCH)
                    w.salt = epoch_salt(w.ts, w.omega);
                push_word(w, s.known, s.typed);
            end
        end

        // random phases; clean bursts of small errors and good salts build lock
        clean = 1'b0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            reg_write(REG_LOCK_IN, {15'd0, lock_in_set[ph]});
            reg_write(REG_DROP_OUT, {15'd0, drop_set[ph]});
            reg_write(REG_WINDOW, window_set[ph]);
            calm = (ph == 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 24 == 0)
                    clean = ($urandom_range(0, 1) == 0);
                roll = $urandom_range(0, 99);
                mag  = clean ? $urandom_range(0, 1200) : $urandom_range(0, 99);
                if (!clean)
                    mag = (mag < 55) ? $urandom_range(0, 1500) :
                          (mag < 85) ? $urandom_range(0, 30000) : -1;
                if (mag < 0)
                    w.pe = PE_W'($urandom);
                else
                    w.pe = $urandom_range(0, 1) ? PE_W'(-mag) : PE_W'(mag);
                w.ts    = ($urandom_range(0, 9) < 7) ? {16'($urandom), 32'($urandom)}
                                                     : TS_W'($urandom_range(0, 3000000));
                w.omega = {32'($urandom), 32'($urandom)};
                w.salt  = epoch_salt(w.ts, w.omega);
                if (clean) begin
                    if (roll >= 97)
                        w.salt = SALT_W'($urandom_range(0, 1023));
                end else if (roll >= 95) begin
                    // near miss: one bit off
                    w.salt = w.salt ^ (SALT_W'(1) << $urandom_range(0, SALT_W - 1));
                end else if (roll >= 90) begin
                    w.salt = SALT_W'($urandom_range(1000, 1023));
                end else if (roll >= 80) begin
                    w.salt = SALT_W'($urandom_range(0, 1023));
                end
                push_word(w, 1'b0, '0);
            end
        end
        calm = 1'b0;

        // drain, then give the block time to show any stray word
        settle();
        repeat (160) @(posedge i_clk);
        while (lock_reports_due.size() != 0) begin
            s.typed = lock_reports_due.pop_front();
            flag_failure($sformatf("missing result: exp locked=%0b replay=%0b ema=%0d",
                                   s.typed.locked, s.typed.replay, s.typed.ema));
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
